>>> rtl/core/ffa_pkg.sv
// ============================================================================
// ffa_pkg - shared definitions for the first-fit block allocator
// Header layout, operation codes and the controller/datapath interface.
// ============================================================================
package ffa_pkg;

   // Pool geometry
   localparam int POOL_WORDS = 1024;
   localparam int ADDR_W     = $clog2(POOL_WORDS);
   localparam int SIZE_W     = 11;
   localparam int HDR_W      = SIZE_W + 1;
   localparam int CFG_W      = 11;
   localparam int REQ_W      = 14;
   localparam int BYTES_W    = 14;
   localparam int WORD_SHIFT = 3;

   // Walk arithmetic: wide enough for a header offset plus the largest size
   localparam int POS_W      = 12;

   // Header free mark position
   localparam int HDR_FREE   = HDR_W - 1;

   // Operation codes
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic init_wr;   // rebuild the pool header at word zero
      logic start;     // latch the accepted item, issue first read
      logic walk;      // evaluate one header, issue next read
      logic split_wr;  // write the split-off free header
      logic mark_wr;   // write back the free mark
      logic load_rsp;  // move the result into the output register
   } ffa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic free_ok;        // free address names a word inside the pool
      logic fit;            // current free run satisfies the allocation
      logic split_in_pool;  // split header lands inside the pool
      logic more;           // next header still inside the pool
   } ffa_stat_type;

endpackage

>>> rtl/core/ffa_ram.sv
// ============================================================================
// ffa_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module ffa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ffa_dp.sv
// ============================================================================
// ffa_dp - allocator datapath
// Header memory, walk registers, free totals and the output register.
// ============================================================================
module ffa_dp
   import ffa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ffa_cmd_type          cmd,
   output ffa_stat_type         stat,
   input  logic [1:0]           req_kind,
   input  logic [REQ_W-1:0]     req_request_bytes,
   input  logic [ADDR_W-1:0]    req_block_addr,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_pool_words,
   output logic [ADDR_W-1:0]    rsp_grant_addr,
   output logic                 rsp_success,
   output logic [BYTES_W-1:0]   rsp_free_bytes,
   output logic [BYTES_W-1:0]   rsp_largest_bytes
);

   localparam logic [CFG_W-1:0] POOL_MIN = CFG_W'(2);
   localparam logic [CFG_W-1:0] POOL_MAX = CFG_W'(POOL_WORDS);

   // Configuration
   logic [CFG_W-1:0]  pool_ff, pool_in;

   // Walk state
   logic [1:0]        op_ff;
   logic [POS_W-1:0]  h_ff, hold_ff, temp_ff, need_ff;
   logic              in_run_ff;
   logic [POS_W-1:0]  sum_ff, run_ff, best_ff;
   logic [ADDR_W-1:0] res_grant_ff;
   logic              res_ok_ff;

   // Output register
   logic [ADDR_W-1:0]  out_grant_ff;
   logic               out_ok_ff;
   logic [BYTES_W-1:0] out_free_ff, out_largest_ff;

   // Memory ports
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [HDR_W-1:0]  wr_data, rd_data;

   // Header decode and walk arithmetic
   logic              hd_free;
   logic [POS_W-1:0]  hd_size, h_next, temp_new, hold_new, split_pos, split_size;
   logic [POS_W-1:0]  run_new;
   logic [POS_W:0]    need_plus;
   logic              is_alloc, fit_split, fit_whole;
   logic [POS_W-1:0]  pool_pos;
   logic [REQ_W:0]    round_bytes;
   logic [ADDR_W-1:0] free_addr;

   function automatic logic [BYTES_W-1:0] to_bytes(input logic [POS_W-1:0] words);
      logic [POS_W+WORD_SHIFT-1:0] b;
      b = {words, WORD_SHIFT'(0)};
      if (b > (POS_W+WORD_SHIFT)'({BYTES_W{1'b1}})) begin
         return {BYTES_W{1'b1}};
      end
      return b[BYTES_W-1:0];
   endfunction

   assign pool_pos   = POS_W'(pool_ff);
   assign is_alloc   = (op_ff == KIND_ALLOC);
   assign hd_free    = rd_data[HDR_FREE];
   assign hd_size    = POS_W'(rd_data[SIZE_W-1:0]);
   assign h_next     = h_ff + POS_W'(1) + hd_size;
   assign temp_new   = in_run_ff ? (temp_ff + POS_W'(1) + hd_size) : hd_size;
   assign hold_new   = in_run_ff ? hold_ff : h_ff;
   assign need_plus  = {1'b0, need_ff} + (POS_W+1)'(1);
   assign fit_split  = is_alloc && hd_free && ({1'b0, temp_new} >= need_plus);
   assign fit_whole  = is_alloc && hd_free && (temp_new >= need_ff);
   assign split_pos  = hold_ff + need_ff + POS_W'(1);
   assign split_size = temp_ff - need_ff - POS_W'(1);
   assign run_new    = hd_free ? (run_ff + hd_size) : '0;
   assign round_bytes = {1'b0, req_request_bytes} + (REQ_W+1)'(7);
   assign free_addr  = req_block_addr - ADDR_W'(1);

   assign stat.free_ok       = (req_block_addr != '0) &&
                               (CFG_W'(free_addr) < pool_ff);
   assign stat.fit           = fit_whole;
   assign stat.split_in_pool = fit_split && ((hold_new + need_ff + POS_W'(1)) < pool_pos);
   assign stat.more          = h_next < pool_pos;

   // Clamp the written pool size into range
   always_comb begin
      pool_in = pool_ff;
      if (csr_wr_en) begin
         if (csr_pool_words < POOL_MIN) begin
            pool_in = POOL_MIN;
         end else if (csr_pool_words > POOL_MAX) begin
            pool_in = POOL_MAX;
         end else begin
            pool_in = csr_pool_words;
         end
      end
   end

   // Memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, SIZE_W'(pool_ff - CFG_W'(1))};
      end else if (cmd.walk && is_alloc && hd_free) begin
         // merge into the run head, or claim it on a fit
         wr_en   = 1'b1;
         wr_addr = hold_new[ADDR_W-1:0];
         if (fit_split) begin
            wr_data = {1'b0, need_ff[SIZE_W-1:0]};
         end else if (fit_whole) begin
            wr_data = {1'b0, temp_new[SIZE_W-1:0]};
         end else begin
            wr_data = {1'b1, temp_new[SIZE_W-1:0]};
         end
      end else if (cmd.split_wr) begin
         wr_en   = 1'b1;
         wr_addr = split_pos[ADDR_W-1:0];
         wr_data = {1'b1, split_size[SIZE_W-1:0]};
      end else if (cmd.mark_wr) begin
         wr_en   = 1'b1;
         wr_addr = hold_ff[ADDR_W-1:0];
         wr_data = rd_data | (HDR_W'(1) << HDR_FREE);
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = h_next[ADDR_W-1:0];
      if (cmd.start) begin
         rd_en   = req_kind inside {KIND_ALLOC, KIND_QUERY, KIND_FREE};
         rd_addr = (req_kind == KIND_FREE) ? free_addr : '0;
      end else if (cmd.walk) begin
         rd_en   = 1'b1;
      end
   end

   ffa_ram #(
      .WIDTH (HDR_W),
      .DEPTH (POOL_WORDS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= POOL_MAX;
      end else begin
         pool_ff <= pool_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff        <= req_kind;
         need_ff      <= round_bytes[REQ_W:WORD_SHIFT];
         h_ff         <= '0;
         hold_ff      <= POS_W'(free_addr);
         temp_ff      <= '0;
         in_run_ff    <= 1'b0;
         sum_ff       <= '0;
         run_ff       <= '0;
         best_ff      <= '0;
         res_grant_ff <= '0;
         res_ok_ff    <= (req_kind == KIND_QUERY) ||
                         ((req_kind == KIND_FREE) && stat.free_ok);
      end else if (cmd.walk) begin
         h_ff <= h_next;
         if (is_alloc) begin
            in_run_ff <= hd_free;
            hold_ff   <= hold_new;
            temp_ff   <= temp_new;
            if (fit_whole) begin
               res_ok_ff    <= 1'b1;
               res_grant_ff <= hold_new[ADDR_W-1:0] + ADDR_W'(1);
            end
         end else begin
            if (hd_free) begin
               sum_ff <= sum_ff + hd_size;
            end
            run_ff <= run_new;
            if (run_new > best_ff) begin
               best_ff <= run_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_grant_ff   <= res_grant_ff;
         out_ok_ff      <= res_ok_ff;
         out_free_ff    <= (op_ff == KIND_QUERY) ? to_bytes(sum_ff)  : '0;
         out_largest_ff <= (op_ff == KIND_QUERY) ? to_bytes(best_ff) : '0;
      end
   end

   assign rsp_grant_addr    = out_grant_ff;
   assign rsp_success       = out_ok_ff;
   assign rsp_free_bytes    = out_free_ff;
   assign rsp_largest_bytes = out_largest_ff;

endmodule

>>> rtl/core/ffa_ctrl.sv
// ============================================================================
// ffa_ctrl - allocator controller
// Sequences init, header walks, split and free writes, and the result handoff.
// ============================================================================
module ffa_ctrl
   import ffa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_kind,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         csr_wr_en,
   input  ffa_stat_type stat,
   output ffa_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WALK  = 5'b00010,
      S_SPLIT = 5'b00100,
      S_MARK  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       init_pend_ff, init_pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE) || init_pend_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.init_wr = init_pend_ff;
            if (accept) begin
               cmd.start = 1'b1;
               op_in     = req_kind;
               if (req_kind inside {KIND_ALLOC, KIND_QUERY}) begin
                  state_in = S_WALK;
               end else if ((req_kind == KIND_FREE) && stat.free_ok) begin
                  state_in = S_MARK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if ((op_ff == KIND_ALLOC) && stat.fit) begin
               state_in = stat.split_in_pool ? S_SPLIT : S_DONE;
            end else if (!stat.more) begin
               state_in = S_DONE;
            end
         end
         S_SPLIT: begin
            cmd.split_wr = 1'b1;
            state_in     = S_DONE;
         end
         S_MARK: begin
            cmd.mark_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      init_pend_in = init_pend_ff;
      if (csr_wr_en) begin
         init_pend_in = 1'b1;
      end else if (cmd.init_wr) begin
         init_pend_in = 1'b0;
      end
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= KIND_ALLOC;
         init_pend_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         init_pend_ff <= init_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// ============================================================================
// first_fit_block_allocator - first-fit heap allocator with lazy coalescing
// Top level: controller plus header datapath.
// ============================================================================
// The pool is up to 1024 words of 8 bytes, set by pool_words, tiled by
// blocks that each start with a 12-bit header (free mark, size in words).
// Allocate rounds the request up to words and walks the header chain from
// word zero at one header per cycle through the header RAM's registered read
// port, merging runs of free blocks into the first block of the run and
// taking the first block that fits, then writing a split-off free header if
// that header lands inside the pool. An allocate or query item walks the
// chain and then loads the result; a free reads the header, writes back the
// free mark and loads the result, and an ignored free or an unknown kind
// goes straight to the result load. One item is worked on at a time, but the
// next item is taken while a finished result still waits in the output
// register. After reset, and once a pool_words write has set the pending
// flag, the block rewrites word zero as a single free block when idle, with
// req_stall high until done. Write pool_words only while the block is idle.
// ============================================================================
module first_fit_block_allocator
   import ffa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [REQ_W-1:0]   req_request_bytes,
   input  logic [ADDR_W-1:0]  req_block_addr,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_grant_addr,
   output logic               rsp_success,
   output logic [BYTES_W-1:0] rsp_free_bytes,
   output logic [BYTES_W-1:0] rsp_largest_bytes,
   // configuration
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_pool_words
);

   ffa_cmd_type  cmd;
   ffa_stat_type stat;

   // Sequence each item; hold requests while busy or rebuilding the pool
   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_wr_en (csr_wr_en),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Header memory, walk arithmetic and the result register
   ffa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_request_bytes (req_request_bytes),
      .req_block_addr    (req_block_addr),
      .csr_wr_en         (csr_wr_en),
      .csr_pool_words    (csr_pool_words),
      .rsp_grant_addr    (rsp_grant_addr),
      .rsp_success       (rsp_success),
      .rsp_free_bytes    (rsp_free_bytes),
      .rsp_largest_bytes (rsp_largest_bytes)
   );

endmodule
